[rtl/assert_macros.svh]
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/sxt_pkg.sv]
// Shared types, codes and character-class helpers for the s-expression tokenizer.
// No dependencies.
package sxt_pkg;

   localparam int COLUMN_BITS = 16;
   localparam int LINE_BITS   = 20;

   typedef logic [COLUMN_BITS-1:0] col_type;
   typedef logic [LINE_BITS-1:0]   line_type;

   // scan modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_COMMENT = 3'd1;
   localparam logic [2:0] MODE_STRING  = 3'd2;
   localparam logic [2:0] MODE_IDENT   = 3'd3;
   localparam logic [2:0] MODE_NUMBER  = 3'd4;
   localparam logic [2:0] MODE_ENDED   = 3'd5;
   localparam logic [2:0] MODE_HALTED  = 3'd6;

   // token kinds
   localparam logic [2:0] KIND_END     = 3'd0;
   localparam logic [2:0] KIND_OPEN    = 3'd1;
   localparam logic [2:0] KIND_CLOSE   = 3'd2;
   localparam logic [2:0] KIND_STRING  = 3'd3;
   localparam logic [2:0] KIND_IDENT   = 3'd4;
   localparam logic [2:0] KIND_KEYWORD = 3'd5;
   localparam logic [2:0] KIND_NUMBER  = 3'd6;
   localparam logic [2:0] KIND_ERROR   = 3'd7;

   // keyword indexes
   localparam logic [2:0] KW_NONE   = 3'd0;
   localparam logic [2:0] KW_DEFINE = 3'd1;
   localparam logic [2:0] KW_LOAD   = 3'd2;
   localparam logic [2:0] KW_LAMBDA = 3'd3;
   localparam logic [2:0] KW_SET    = 3'd4;
   localparam logic [2:0] KW_IF     = 3'd5;

   // error causes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
   localparam logic [1:0] ERR_NL_STR   = 2'd2;
   localparam logic [1:0] ERR_END_STR  = 2'd3;

   // characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0] mode;
      logic [47:0] win;        // last six identifier chars, newest in low byte
      col_type run;
      line_type line;
      col_type col;
      col_type tok;
   } lex_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] keyword_index;
      logic [1:0] error_cause;
      line_type line;
      col_type start_col;
      col_type end_col;
      col_type length;
      logic last;
   } rsp_type;

   function automatic col_type col_inc(input col_type v);
      return (v == {COLUMN_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic line_type line_inc(input line_type v);
      return (v == {LINE_BITS{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
             (c == 8'h21) || (c == 8'h3D) || (c == 8'h3C) || (c == 8'h3E) ||
             (c == 8'h26) || (c == 8'h7C) || (c == 8'h3F);
   endfunction

   function automatic logic [2:0] keyword_of(input logic [47:0] win, input col_type run);
      logic [2:0] kw;
      kw = KW_NONE;
      if (run == COLUMN_BITS'(6) && win == 48'("define")) begin
         kw = KW_DEFINE;
      end else if (run == COLUMN_BITS'(4) && win[31:0] == 32'("load")) begin
         kw = KW_LOAD;
      end else if (run == COLUMN_BITS'(6) && win == 48'("lambda")) begin
         kw = KW_LAMBDA;
      end else if (run == COLUMN_BITS'(4) && win[31:0] == 32'("set!")) begin
         kw = KW_SET;
      end else if (run == COLUMN_BITS'(2) && win[15:0] == 16'("if")) begin
         kw = KW_IF;
      end
      return kw;
   endfunction

   function automatic logic [15:0] fit16(input col_type v);
      logic [31:0] t;
      t = 32'(v);
      return t[15:0];
   endfunction

   function automatic logic [19:0] fit20(input line_type v);
      logic [31:0] t;
      t = 32'(v);
      return t[19:0];
   endfunction

endpackage

[rtl/sxt_lex_step.sv]
// Next-state and token logic for one character or end mark.
// Depends on sxt_pkg.
module sxt_lex_step (
   input  sxt_pkg::lex_state_type st,
   input  logic [7:0]             ch,
   input  logic                   at_end,
   output sxt_pkg::lex_state_type st_in,
   output sxt_pkg::rsp_type       res0,
   output sxt_pkg::rsp_type       res1,
   output logic [1:0]             res_cnt
);
   import sxt_pkg::*;

   col_type col;
   col_type after;
   logic [2:0] close_kw;
   rsp_type close_rec;
   rsp_type end_rec;

   // char handling with no token open
   logic idle_emit;
   rsp_type idle_rec;
   logic [2:0] idle_mode;
   logic idle_start;
   col_type idle_run;
   logic idle_win_load;

   logic use_idle;
   logic closed;

   function automatic rsp_type mk(input logic [2:0] kind, input logic [2:0] kw,
                                  input logic [1:0] cause, input line_type ln,
                                  input col_type s, input col_type e, input col_type len);
      rsp_type r;
      r.kind = kind;
      r.keyword_index = kw;
      r.error_cause = cause;
      r.line = ln;
      r.start_col = s;
      r.end_col = e;
      r.length = len;
      r.last = 1'b0;
      return r;
   endfunction

   assign col   = col_inc(st.col);
   assign after = col_inc(col);
   assign close_kw = keyword_of(st.win, st.run);

   always_comb begin
      close_rec = mk((st.mode == MODE_IDENT) ?
                     ((close_kw != KW_NONE) ? KIND_KEYWORD : KIND_IDENT) : KIND_NUMBER,
                     (st.mode == MODE_IDENT) ? close_kw : KW_NONE,
                     ERR_NONE, st.line, st.tok, col, st.run);
      end_rec = mk(KIND_END, KW_NONE, ERR_NONE, st.line, col, col, '0);
   end

   always_comb begin
      idle_emit = 1'b0;
      idle_rec = mk(KIND_OPEN, KW_NONE, ERR_NONE, st.line, col, after, COLUMN_BITS'(1));
      idle_mode = MODE_IDLE;
      idle_start = 1'b0;
      idle_run = '0;
      idle_win_load = 1'b0;
      priority if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL) begin
      end else if (ch == CH_SEMI) begin
         idle_mode = MODE_COMMENT;
      end else if (ch == CH_LPAREN || ch == CH_LBRACK) begin
         idle_emit = 1'b1;
      end else if (ch == CH_RPAREN || ch == CH_RBRACK) begin
         idle_emit = 1'b1;
         idle_rec.kind = KIND_CLOSE;
      end else if (ch == CH_QUOTE) begin
         idle_mode = MODE_STRING;
         idle_start = 1'b1;
      end else if (is_ident(ch)) begin
         idle_mode = MODE_IDENT;
         idle_start = 1'b1;
         idle_run = COLUMN_BITS'(1);
         idle_win_load = 1'b1;
      end else if (is_digit(ch)) begin
         idle_mode = MODE_NUMBER;
         idle_start = 1'b1;
         idle_run = COLUMN_BITS'(1);
      end else begin
         idle_emit = 1'b1;
         idle_rec.kind = KIND_ERROR;
         idle_rec.error_cause = ERR_BAD_CHAR;
         idle_mode = MODE_HALTED;
      end
   end

   always_comb begin
      st_in = st;
      res0 = end_rec;
      res1 = end_rec;
      res_cnt = 2'd0;
      use_idle = 1'b0;
      closed = 1'b0;

      priority if (st.mode == MODE_HALTED) begin
      end else if (st.mode == MODE_ENDED) begin
         if (at_end) begin
            res_cnt = 2'd1;
         end
      end else if (at_end) begin
         unique case (st.mode)
            MODE_STRING: begin
               res0 = mk(KIND_ERROR, KW_NONE, ERR_END_STR, st.line, st.tok, col, st.run);
               res_cnt = 2'd1;
               st_in.mode = MODE_HALTED;
            end
            MODE_IDENT, MODE_NUMBER: begin
               res0 = close_rec;
               res_cnt = 2'd2;
               st_in.mode = MODE_ENDED;
            end
            default: begin
               res_cnt = 2'd1;
               st_in.mode = MODE_ENDED;
            end
         endcase
      end else begin
         unique case (st.mode)
            MODE_COMMENT: begin
               if (ch == CH_NL) begin
                  st_in.mode = MODE_IDLE;
               end
            end
            MODE_STRING: begin
               if (ch == CH_QUOTE) begin
                  res0 = mk(KIND_STRING, KW_NONE, ERR_NONE, st.line, st.tok, after, st.run);
                  res_cnt = 2'd1;
                  st_in.mode = MODE_IDLE;
               end else if (ch == CH_NL) begin
                  res0 = mk(KIND_ERROR, KW_NONE, ERR_NL_STR, st.line, st.tok, col, st.run);
                  res_cnt = 2'd1;
                  st_in.mode = MODE_HALTED;
               end else begin
                  st_in.run = col_inc(st.run);
               end
            end
            MODE_IDENT: begin
               if (is_ident(ch)) begin
                  st_in.run = col_inc(st.run);
                  st_in.win = {st.win[39:0], ch};
               end else begin
                  closed = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(ch)) begin
                  st_in.run = col_inc(st.run);
               end else begin
                  closed = 1'b1;
                  use_idle = 1'b1;
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase

         if (closed) begin
            res0 = close_rec;
            res_cnt = 2'd1;
         end
         if (use_idle) begin
            st_in.mode = idle_mode;
            if (idle_start) begin
               st_in.tok = col;
               st_in.run = idle_run;
            end
            if (idle_win_load) begin
               st_in.win = {40'b0, ch};
            end
            if (idle_emit) begin
               if (closed) begin
                  res1 = idle_rec;
                  res_cnt = 2'd2;
               end else begin
                  res0 = idle_rec;
                  res_cnt = 2'd1;
               end
            end
         end

         if (ch == CH_NL) begin
            st_in.col = '0;
            st_in.line = line_inc(st.line);
         end else begin
            st_in.col = col;
         end
      end

      res0.last = (res_cnt == 2'd1);
      res1.last = 1'b1;
   end

endmodule

[rtl/sxt_rsp_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one per beat.
// Depends on sxt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sxt_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          push_cnt,
   input  sxt_pkg::rsp_type                    push0,
   input  sxt_pkg::rsp_type                    push1,
   input  logic                                pop,
   output sxt_pkg::rsp_type                    head,
   output logic [sxt_pkg::RSP_CNT_BITS-1:0]    count
);
   import sxt_pkg::*;

   rsp_type mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in;
   logic [RSP_PTR_BITS-1:0] rd_ff, rd_in;
   logic [RSP_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RSP_PTR_BITS-1:0] wr_nxt;

   assign wr_nxt = wr_ff + 1'b1;
   assign wr_in  = wr_ff + RSP_PTR_BITS'(push_cnt);
   assign rd_in  = rd_ff + RSP_PTR_BITS'(pop);
   assign cnt_in = cnt_ff + RSP_CNT_BITS'(push_cnt) - RSP_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_nxt] <= push1;
      end
   end

   assign head  = mem_ff[rd_ff];
   assign count = cnt_ff;

   `ASSERT_HOLDS(a_cnt_bound, clock, reset, cnt_ff <= RSP_CNT_BITS'(RSP_DEPTH))
   `ASSERT_HOLDS(a_no_overflow, clock, reset, (32'(cnt_ff) + 32'(push_cnt)) <= RSP_DEPTH)
   `ASSERT_HOLDS(a_no_underflow, clock, reset, !(pop && cnt_ff == '0))

endmodule

[rtl/s_expression_tokenizer_top.sv]
// A token is queued when the character ending it is taken; rsp_ shows the queue head.
// Throughput: one character per cycle when not stalled; results leave one per beat, so a
// character that yields two tokens (run end plus open/close/error/end) takes two beats.
// req_stall rises when the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active high) clears scan state, counters, window and queue.
//
// Top level of the s-expression tokenizer. Depends on sxt_pkg, sxt_lex_step,
// sxt_rsp_fifo and assert_macros.svh.
`include "assert_macros.svh"
module s_expression_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   // character beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_at_end,
   // token beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_keyword_index,
   output logic [1:0]  rsp_error_cause,
   output logic [19:0] rsp_line,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_end_column,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import sxt_pkg::*;

   // Scanner state: mode, keyword window, run length, line/column, token start.
   lex_state_type state_ff, state_in;

   rsp_type res0, res1, head;
   logic [1:0] res_cnt;
   logic [1:0] push_cnt;
   logic [RSP_CNT_BITS-1:0] q_count;
   logic accept;
   logic pop;

   // Every beat must find room for two tokens, so stall once fewer are free.
   assign req_stall = (q_count > RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   // One-pass step: all token decisions for this beat come from the current state.
   sxt_lex_step u_step (
      .st      (state_ff),
      .ch      (req_ch),
      .at_end  (req_at_end),
      .st_in   (state_in),
      .res0    (res0),
      .res1    (res1),
      .res_cnt (res_cnt)
   );

   // State only advances on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= MODE_IDLE;
         state_ff.win  <= '0;
         state_ff.run  <= '0;
         state_ff.line <= '0;
         state_ff.col  <= '0;
         state_ff.tok  <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign push_cnt = accept ? res_cnt : 2'd0;
   assign pop      = rsp_valid && !rsp_stall;

   // Result queue decouples the output handshake from the scanner.
   sxt_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .push0    (res0),
      .push1    (res1),
      .pop      (pop),
      .head     (head),
      .count    (q_count)
   );

   assign rsp_valid         = (q_count != '0);
   assign rsp_kind          = head.kind;
   assign rsp_keyword_index = head.keyword_index;
   assign rsp_error_cause   = head.error_cause;
   assign rsp_line          = fit20(head.line);
   assign rsp_start_column  = fit16(head.start_col);
   assign rsp_end_column    = fit16(head.end_col);
   assign rsp_token_length  = fit16(head.length);
   assign rsp_last_of_run   = head.last;

   // After an error the scanner stays silent until reset.
   `ASSERT_NEXT(a_halt_sticky, clock, reset, state_ff.mode == MODE_HALTED, state_ff.mode == MODE_HALTED)
   `ASSERT_NEXT(a_end_sticky, clock, reset, state_ff.mode == MODE_ENDED, state_ff.mode == MODE_ENDED)
   `ASSERT_HOLDS(a_halt_quiet, clock, reset, !(state_ff.mode == MODE_HALTED && push_cnt != 2'd0))
   `ASSERT_NEXT(a_line_mono, clock, reset, 1'b1, state_ff.line >= $past(state_ff.line))

endmodule
